// ===== rtl/core/ffha_pkg.sv =====
// Shared types, constants and codes for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 20;
    localparam int ALIGN_BYTES  = 32;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] HDR        = 32'(HEADER_BYTES);
    localparam logic [32:0] ALIGN_M1   = 33'(ALIGN_BYTES - 1);
    localparam logic [31:0] BASE_RST   = 32'd589824;
    localparam logic [31:0] BYTES_RST  = 32'd1048576;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_NXT,
        RD_SRC
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_NX_RD,
        S_NX_EV,
        S_MSETUP,
        S_SH_RD,
        S_SH_WR,
        S_FIN1,
        S_FIN2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

    typedef struct packed {
        logic    init;
        logic    start;
        t_rd_sel rd_sel;
        logic    eval;
        logic    idx_inc;
        logic    cap_next;
        logic    clr_next;
        logic    sh_up_setup;
        logic    sh_dn_setup;
        logic    sh_wr;
        logic    fin1;
        logic    fin2;
        logic    set_st;
        t_status st;
        logic    out_load;
    } t_ctl;

    typedef struct packed {
        logic is_release;
        logic paddr_zero;
        logic scan_end;
        logic fit;
        logic split;
        logic full;
        logic match;
        logic cur_free;
        logic has_next;
        logic merge_any;
        logic sh_more;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// First-fit heap allocator with coalescing: top level joining controller
// and datapath. Depends on ffha_pkg, ffha_ctrl, ffha_dp, ffha_ram.
// Each transaction scans table entries in order, then shifts entries to make
// room for a split or to close a merge. One transaction at a time: the input
// stalls until the result is loaded into the output register.
// Reset and any configuration write rebuild the table.
`default_nettype none
module first_fit_heap_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [31:0] i_payload_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_granted_address,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    ffha_pkg::t_ctl    w_ctl;
    ffha_pkg::t_dp_sts w_sts;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    ffha_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_cmd             (i_cmd),
        .i_request_bytes   (i_request_bytes),
        .i_payload_address (i_payload_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status)
    );
endmodule
`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// Controller state machine of the heap allocator.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_cfg_we,
    input  ffha_pkg::t_dp_sts    i_sts,
    output ffha_pkg::t_ctl       o_ctl,
    output logic                 o_in_stall
);
    ffha_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_ctl      = '0;
        o_ctl.rd_sel = ffha_pkg::RD_IDX;
        o_ctl.st   = ffha_pkg::ST_OK;
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            ffha_pkg::S_INIT: begin
                o_ctl.init = 1'b1;
                n_state    = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.start = 1'b1;
                    n_state     = ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                o_ctl.rd_sel = ffha_pkg::RD_IDX;
                if (i_sts.is_release && i_sts.paddr_zero) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ffha_pkg::ST_IGNORED;
                    n_state      = ffha_pkg::S_RESP;
                end else if (i_sts.scan_end) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = i_sts.is_release ? ffha_pkg::ST_IGNORED
                                                    : ffha_pkg::ST_NOSPACE;
                    n_state      = ffha_pkg::S_RESP;
                end else begin
                    n_state = ffha_pkg::S_SCAN_EV;
                end
            end
            ffha_pkg::S_SCAN_EV: begin
                o_ctl.eval = 1'b1;
                if (!i_sts.is_release) begin
                    if (i_sts.fit && i_sts.split && i_sts.full) begin
                        o_ctl.set_st = 1'b1;
                        o_ctl.st     = ffha_pkg::ST_FULL;
                        n_state      = ffha_pkg::S_RESP;
                    end else if (i_sts.fit && i_sts.split) begin
                        o_ctl.sh_up_setup = 1'b1;
                        n_state           = ffha_pkg::S_SH_RD;
                    end else if (i_sts.fit) begin
                        n_state = ffha_pkg::S_FIN1;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = ffha_pkg::S_SCAN_RD;
                    end
                end else if (i_sts.match) begin
                    if (i_sts.cur_free) begin
                        o_ctl.set_st = 1'b1;
                        o_ctl.st     = ffha_pkg::ST_IGNORED;
                        n_state      = ffha_pkg::S_RESP;
                    end else if (i_sts.has_next) begin
                        n_state = ffha_pkg::S_NX_RD;
                    end else begin
                        o_ctl.clr_next = 1'b1;
                        n_state        = ffha_pkg::S_MSETUP;
                    end
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_NX_RD: begin
                o_ctl.rd_sel = ffha_pkg::RD_NXT;
                n_state      = ffha_pkg::S_NX_EV;
            end
            ffha_pkg::S_NX_EV: begin
                o_ctl.cap_next = 1'b1;
                n_state        = ffha_pkg::S_MSETUP;
            end
            ffha_pkg::S_MSETUP: begin
                if (i_sts.merge_any) begin
                    o_ctl.sh_dn_setup = 1'b1;
                    n_state           = ffha_pkg::S_SH_RD;
                end else begin
                    n_state = ffha_pkg::S_FIN1;
                end
            end
            ffha_pkg::S_SH_RD: begin
                o_ctl.rd_sel = ffha_pkg::RD_SRC;
                n_state = i_sts.sh_more ? ffha_pkg::S_SH_WR : ffha_pkg::S_FIN1;
            end
            ffha_pkg::S_SH_WR: begin
                o_ctl.sh_wr = 1'b1;
                n_state     = ffha_pkg::S_SH_RD;
            end
            ffha_pkg::S_FIN1: begin
                o_ctl.fin1 = 1'b1;
                n_state    = ffha_pkg::S_FIN2;
            end
            ffha_pkg::S_FIN2: begin
                o_ctl.fin2   = 1'b1;
                o_ctl.set_st = 1'b1;
                o_ctl.st     = ffha_pkg::ST_OK;
                n_state      = ffha_pkg::S_RESP;
            end
            ffha_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::S_INIT;
            end
        endcase
        if (i_cfg_we) begin
            n_state = ffha_pkg::S_INIT;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ffha_dp.sv =====
// Datapath of the heap allocator: block table RAM, scan and shift pointers,
// configuration and result registers. Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  ffha_pkg::t_ctl         i_ctl,
    output ffha_pkg::t_dp_sts      o_sts,
    input  wire logic              i_cmd,
    input  wire logic [31:0]       i_request_bytes,
    input  wire logic [31:0]       i_payload_address,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [31:0]            o_granted_address,
    output logic [1:0]             o_status
);
    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;

    logic [31:0]       r_base, r_bytes;
    logic              r_cmd;
    logic [32:0]       r_need;
    logic [31:0]       r_paddr;
    logic [CW-1:0]     r_count, r_idx, r_src, r_dst;
    logic              r_up;
    ffha_pkg::t_entry  r_cur, r_prev, r_nxt;
    logic              r_nf;
    logic [31:0]       r_grant;
    ffha_pkg::t_status r_st;

    ffha_pkg::t_entry  w_dout, w_wdata;
    logic [64:0]       w_rdata;
    logic              w_we;
    logic [IW-1:0]     w_waddr, w_raddr;
    logic [32:0]       w_req_up;
    logic [31:0]       w_rest_d, w_rest_c, w_nsum, w_rel_size;
    logic              w_split_c, w_pf, w_merge;
    logic [CW-1:0]     w_n, w_d, w_idx1;

    ffha_ram #(.WIDTH($bits(ffha_pkg::t_entry)), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_dout    = ffha_pkg::t_entry'(w_rdata);
    assign w_idx1    = r_idx + CW'(1);
    assign w_req_up  = {1'b0, i_request_bytes} + ffha_pkg::ALIGN_M1;
    assign w_rest_d  = w_dout.size - r_need[31:0];
    assign w_rest_c  = r_cur.size - r_need[31:0];
    assign w_split_c = w_rest_c > ffha_pkg::HDR;
    assign w_pf      = r_prev.free && (r_idx != '0);
    assign w_merge   = w_pf || r_nf;
    assign w_n       = (w_pf && r_nf) ? CW'(2) : CW'(1);
    assign w_d       = w_pf ? r_idx : w_idx1;
    assign w_nsum    = r_nf ? (r_nxt.size + ffha_pkg::HDR) : 32'd0;
    assign w_rel_size = w_pf ? (r_prev.size + r_cur.size + ffha_pkg::HDR + w_nsum)
                             : (r_cur.size + w_nsum);

    always_comb begin
        case (i_ctl.rd_sel)
            ffha_pkg::RD_NXT: w_raddr = w_idx1[IW-1:0];
            ffha_pkg::RD_SRC: w_raddr = r_src[IW-1:0];
            default:          w_raddr = r_idx[IW-1:0];
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_wdata = r_cur;
        if (i_ctl.init) begin
            w_we          = 1'b1;
            w_waddr       = '0;
            w_wdata.start = r_base;
            w_wdata.size  = (r_bytes >= ffha_pkg::HDR) ? r_bytes - ffha_pkg::HDR : 32'd0;
            w_wdata.free  = 1'b1;
        end else if (i_ctl.sh_wr) begin
            w_we    = 1'b1;
            w_waddr = r_dst[IW-1:0];
            w_wdata = w_dout;
        end else if (i_ctl.fin1) begin
            w_we          = (r_cmd == ffha_pkg::CMD_ALLOC) && w_split_c;
            w_waddr       = w_idx1[IW-1:0];
            w_wdata.start = r_cur.start + ffha_pkg::HDR + r_need[31:0];
            w_wdata.size  = w_rest_c - ffha_pkg::HDR;
            w_wdata.free  = 1'b1;
        end else if (i_ctl.fin2) begin
            w_we = 1'b1;
            if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                w_wdata.start = r_cur.start;
                w_wdata.size  = w_split_c ? r_need[31:0] : r_cur.size;
                w_wdata.free  = 1'b0;
            end else begin
                w_waddr       = w_pf ? r_idx[IW-1:0] - IW'(1) : r_idx[IW-1:0];
                w_wdata.start = w_pf ? r_prev.start : r_cur.start;
                w_wdata.size  = w_rel_size;
                w_wdata.free  = 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.is_release = r_cmd == ffha_pkg::CMD_RELEASE;
        o_sts.paddr_zero = r_paddr == 32'd0;
        o_sts.scan_end   = r_idx >= r_count;
        o_sts.fit        = w_dout.free && ({1'b0, w_dout.size} >= r_need);
        o_sts.split      = w_rest_d > ffha_pkg::HDR;
        o_sts.full       = r_count == CW'(ffha_pkg::MAX_BLOCKS);
        o_sts.match      = (w_dout.start + ffha_pkg::HDR) == r_paddr;
        o_sts.cur_free   = w_dout.free;
        o_sts.has_next   = w_idx1 < r_count;
        o_sts.merge_any  = w_merge;
        o_sts.sh_more    = r_up ? (r_src > r_idx) : (r_src < r_count);
        o_sts.out_free   = !o_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ffha_pkg::BASE_RST;
            r_bytes     <= ffha_pkg::BYTES_RST;
            r_count     <= CW'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ffha_pkg::CFG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_bytes <= i_cfg_data;
                end
            end
            if (i_ctl.init) begin
                r_count <= CW'(1);
            end else if (i_ctl.fin2) begin
                if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                    if (w_split_c) begin
                        r_count <= r_count + CW'(1);
                    end
                end else if (w_merge) begin
                    r_count <= r_count - w_n;
                end
            end
            if (i_ctl.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd   <= i_cmd;
            r_need  <= w_req_up & ~ffha_pkg::ALIGN_M1;
            r_paddr <= i_payload_address;
            r_idx   <= '0;
            r_grant <= 32'd0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= w_idx1;
        end
        if (i_ctl.eval) begin
            r_cur  <= w_dout;
            r_prev <= r_cur;
        end
        if (i_ctl.cap_next) begin
            r_nxt <= w_dout;
            r_nf  <= w_dout.free;
        end else if (i_ctl.clr_next) begin
            r_nf <= 1'b0;
        end
        if (i_ctl.sh_up_setup) begin
            r_up  <= 1'b1;
            r_src <= r_count - CW'(1);
            r_dst <= r_count;
        end else if (i_ctl.sh_dn_setup) begin
            r_up  <= 1'b0;
            r_src <= w_d + w_n;
            r_dst <= w_d;
        end else if (i_ctl.sh_wr) begin
            r_src <= r_up ? r_src - CW'(1) : r_src + CW'(1);
            r_dst <= r_up ? r_dst - CW'(1) : r_dst + CW'(1);
        end
        if (i_ctl.fin2 && (r_cmd == ffha_pkg::CMD_ALLOC)) begin
            r_grant <= r_cur.start + ffha_pkg::HDR;
        end
        if (i_ctl.set_st) begin
            r_st <= i_ctl.st;
        end
        if (i_ctl.out_load) begin
            o_granted_address <= r_grant;
            o_status          <= r_st;
        end
    end
endmodule
`default_nettype wire
